### design/sidechain_combine_mixer_unit_macros.svh
// ---------------------------------------------------------------------------
// Sidechain combine mixer assertion macros
// Shared check forms for the mixer pipeline; clocked on clk, idle in reset.
// ---------------------------------------------------------------------------
`ifndef SIDECHAIN_COMBINE_MIXER_UNIT_MACROS_SVH
`define SIDECHAIN_COMBINE_MIXER_UNIT_MACROS_SVH

// same-cycle implication
`define SCM_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SCM_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/scm_pkg.sv
// ---------------------------------------------------------------------------
// Sidechain combine mixer package
// Fixed-point constants, mode codes, register indexes and stage positions.
// ---------------------------------------------------------------------------
`default_nettype none

package scm_pkg;

  localparam int DEF_SAMPLE_BITS = 16;

  // operation codes of the mode register
  localparam logic [2:0] MODE_SINPROD = 3'd0;
  localparam logic [2:0] MODE_SINSIN  = 3'd1;
  localparam logic [2:0] MODE_MINMAG  = 3'd2;
  localparam logic [2:0] MODE_MAXMAG  = 3'd3;
  localparam logic [2:0] MODE_DIFFSQ  = 3'd4;
  localparam logic [2:0] MODE_TRIPLE  = 3'd5;
  localparam logic [2:0] MODE_SINTAN  = 3'd6;
  localparam logic [2:0] MODE_THRU    = 3'd7;

  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] REG_MODE = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIX  = 4'd1;

  localparam logic [15:0] MIX_RESET = 16'd16384;
  localparam logic [15:0] MIX_FULL  = 16'd32768;

  // 2^32 / (2*pi), radians in Q.30 to turn phase
  localparam logic [30:0] INV_TWO_PI = 31'd683565276;

  // odd Taylor terms of sin on the quarter wave, Q.30
  localparam logic [30:0] C1_Q30 = 31'd1686629713;
  localparam logic [30:0] C3_Q30 = 31'd693598669;
  localparam logic [30:0] C5_Q30 = 31'd85569306;
  localparam logic [30:0] C7_Q30 = 31'd5026995;
  localparam logic [30:0] C9_Q30 = 31'd172272;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  typedef logic signed [31:0] q30_t;
  typedef logic signed [34:0] wide_t;

  localparam int SIN_LAT   = 7;
  localparam int DIV_STEPS = 31;
  localparam int SOT_LAT   = 2 + SIN_LAT + 1 + DIV_STEPS + 2 + SIN_LAT;

  // stage positions counted from the input register (stage 1)
  localparam int STG_SOT   = 1 + SOT_LAT;
  localparam int STG_P1    = STG_SOT + 1;
  localparam int STG_P2    = STG_P1 + 1;
  localparam int STG_WET   = STG_P2 + 1;
  localparam int STG_MIX   = STG_WET + 1;
  localparam int STG_OUT   = STG_MIX + 1;
  localparam int STG_EARLY = STG_WET - 3 - SIN_LAT;
  localparam int STG_SQ    = STG_WET - 4;

endpackage

`default_nettype wire

### design/scm_sin.sv
// ---------------------------------------------------------------------------
// Sidechain combine mixer sine unit
// Pipelined sine of a 32-bit turn phase by a Horner polynomial, Q.30 result.
// ---------------------------------------------------------------------------
`default_nettype none

module scm_sin (
  input  logic         clk,
  input  logic [31:0]  phase,
  output scm_pkg::q30_t sin_val
);

  logic [30:0] x1, x2, x3, x4, x5, x6;
  logic        n1, n2, n3, n4, n5, n6;
  logic [30:0] y2, y3, y4, y5;
  logic [30:0] acc3, acc4, acc5, acc6;
  logic [61:0] sq, m3, m4, m5, m6, m7;
  logic [30:0] r7, rc7;

  assign sq = x1 * x1;
  assign m3 = scm_pkg::C9_Q30 * y2;
  assign m4 = acc3 * y3;
  assign m5 = acc4 * y4;
  assign m6 = acc5 * y5;
  assign m7 = acc6 * x6;
  assign r7 = m7[60:30];
  assign rc7 = (r7 > scm_pkg::ONE_Q30) ? scm_pkg::ONE_Q30 : r7;

  always_ff @(posedge clk) begin
    // fold to the first quarter, keep the half-wave sign
    x1 <= phase[30] ? (scm_pkg::ONE_Q30 - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
    n1 <= phase[31];
    y2 <= sq[60:30];
    x2 <= x1;
    n2 <= n1;
    acc3 <= scm_pkg::C7_Q30 - m3[60:30];
    x3 <= x2;
    y3 <= y2;
    n3 <= n2;
    acc4 <= scm_pkg::C5_Q30 - m4[60:30];
    x4 <= x3;
    y4 <= y3;
    n4 <= n3;
    acc5 <= scm_pkg::C3_Q30 - m5[60:30];
    x5 <= x4;
    y5 <= y4;
    n5 <= n4;
    acc6 <= scm_pkg::C1_Q30 - m6[60:30];
    x6 <= x5;
    n6 <= n5;
    sin_val <= n6 ? -$signed({1'b0, rc7}) : $signed({1'b0, rc7});
  end

endmodule

`default_nettype wire

### design/scm_sot.sv
// ---------------------------------------------------------------------------
// Sidechain combine mixer sine-of-tangent unit
// Phase, sine and cosine, pipelined restoring divide for tan, then sine.
// ---------------------------------------------------------------------------
`default_nettype none

module scm_sot (
  input  logic          clk,
  input  scm_pkg::q30_t v,
  output scm_pkg::q30_t sot
);

  localparam int DS = scm_pkg::DIV_STEPS;

  scm_pkg::q30_t v_r, s_w, c_w;
  logic [31:0] ph_r, ph2_r;
  logic signed [63:0] vk;
  logic signed [64:0] tk;
  logic signed [32:0] t_r;
  logic [30:0] s_abs, c_abs;

  logic [30:0]    rem_p [0:DS-1];
  logic [DS-1:0]  nlo_p [0:DS-1];
  logic [30:0]    den_p [0:DS-1];
  logic [DS-1:0]  q_p   [0:DS];
  logic [DS:0]    sat_p;
  logic [DS:0]    neg_p;
  logic [31:0]    trial [0:DS-1];
  logic [DS-1:0]  take;

  assign vk = v_r * $signed({1'b0, scm_pkg::INV_TWO_PI});
  assign tk = t_r * $signed({1'b0, scm_pkg::INV_TWO_PI});
  assign s_abs = s_w[31] ? 31'(-s_w) : s_w[30:0];
  assign c_abs = c_w[31] ? 31'(-c_w) : c_w[30:0];

  scm_sin u_sin_s (.clk(clk), .phase(ph_r), .sin_val(s_w));
  scm_sin u_sin_c (.clk(clk), .phase(ph_r + scm_pkg::QUARTER_TURN), .sin_val(c_w));
  scm_sin u_sin_t (.clk(clk), .phase(ph2_r), .sin_val(sot));

  always_comb begin
    for (int j = 0; j < DS; j++) begin
      trial[j] = {rem_p[j], nlo_p[j][DS-1]};
      take[j]  = trial[j] >= {1'b0, den_p[j]};
    end
  end

  always_ff @(posedge clk) begin
    v_r  <= v;
    ph_r <= vk[61:30];
    // divider setup: quotient overflows exactly when the top bits reach the divisor
    rem_p[0] <= {15'b0, s_abs[30:15]};
    nlo_p[0] <= {s_abs[14:0], 16'b0};
    den_p[0] <= c_abs;
    q_p[0]   <= '0;
    sat_p[0] <= {15'b0, s_abs[30:15]} >= c_abs;
    neg_p[0] <= (c_w == '0) ? s_w[31] : (s_w[31] ^ c_w[31]);
    for (int j = 0; j < DS; j++) begin
      q_p[j+1]   <= {q_p[j][DS-2:0], take[j]};
      sat_p[j+1] <= sat_p[j];
      neg_p[j+1] <= neg_p[j];
    end
    for (int j = 0; j < DS - 1; j++) begin
      rem_p[j+1] <= take[j] ? 31'(trial[j] - {1'b0, den_p[j]}) : trial[j][30:0];
      nlo_p[j+1] <= {nlo_p[j][DS-2:0], 1'b0};
      den_p[j+1] <= den_p[j];
    end
    // saturate tan to +-32768 in Q.16
    if (sat_p[DS]) begin
      t_r <= neg_p[DS] ? 33'sh1_8000_0000 : 33'sh0_8000_0000;
    end else begin
      t_r <= neg_p[DS] ? -$signed({2'b0, q_p[DS]}) : $signed({2'b0, q_p[DS]});
    end
    ph2_r <= tk[47:16];
  end

endmodule

`default_nettype wire

### design/sidechain_combine_mixer_unit.sv
// Throughput: one sample pair per cycle unless busy; busy is a register set during reset.
// Depth is set by the sine-of-tangent path: a 31-stage restoring divider between sine units.
// Reset clears the valid line and loads mode 0 and mix 16384; data stages are not reset.
// The receiver cannot stall: each result is shown for one cycle with done high.
// ---------------------------------------------------------------------------
// Sidechain combine mixer
// Combines a main and a sidechain sample by the selected mode, then blends dry and wet
// by the mix register and saturates to the sample format; pass-through mode outputs main.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sidechain_combine_mixer_unit_macros.svh"

module sidechain_combine_mixer_unit #(
  parameter int SAMPLE_BITS = scm_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [SAMPLE_BITS-1:0]        main_sample,
  input  logic signed [SAMPLE_BITS-1:0]        side_sample,
  output logic                                 done,
  output logic signed [SAMPLE_BITS-1:0]        out_sample,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [scm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [scm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int FRAC   = SAMPLE_BITS - 1;
  localparam int SH     = 30 - FRAC;            // Q1.F to Q.30 shift
  localparam int WB     = SAMPLE_BITS + 2;      // wet value width, Q3.F
  localparam int AW     = SAMPLE_BITS + 20;     // mix accumulator width
  localparam int AD_LEN = scm_pkg::STG_MIX;
  localparam int BD_LEN = scm_pkg::STG_WET - 1;
  localparam int STG_E  = scm_pkg::STG_EARLY;
  localparam int STG_Q  = scm_pkg::STG_SQ;
  localparam logic signed [AW-1:0] SMAX = AW'((1 << FRAC) - 1);
  localparam logic signed [AW-1:0] SMIN = AW'(-(1 << FRAC));
  localparam scm_pkg::wide_t WMAX = 35'((4 << FRAC) - 1);
  localparam scm_pkg::wide_t WMIN = 35'(-(4 << FRAC));
  localparam scm_pkg::wide_t WHALF = 35'(1 << (SH - 1));
  localparam logic signed [AW-1:0] MHALF = AW'(16384);

  // Round a Q.30 wet value half up to Q3.F and saturate.
  function automatic logic signed [WB-1:0] wet_fix(input scm_pkg::wide_t w);
    scm_pkg::wide_t r;
    r = (w + WHALF) >>> SH;
    if (r > WMAX) begin
      r = WMAX;
    end else if (r < WMIN) begin
      r = WMIN;
    end
    return r[WB-1:0];
  endfunction

  function automatic logic signed [30:0] to_q30(input logic signed [SAMPLE_BITS-1:0] s);
    return $signed({s, {SH{1'b0}}});
  endfunction

  // ---- configuration registers ----
  logic [2:0]  mode;
  logic [15:0] mix;
  logic [15:0] mix_eff, inv_mix;

  // ---- valid line and sample delay lines ----
  logic [scm_pkg::STG_OUT:1]       vld;
  logic signed [SAMPLE_BITS-1:0]   ad [1:AD_LEN];
  logic signed [SAMPLE_BITS-1:0]   bd [1:BD_LEN];

  // ---- sine-of-tangent path ----
  logic signed [30:0]  a30_1, b30_1;
  scm_pkg::q30_t       v_sum, v_dif, v_neg;
  scm_pkg::q30_t       t_sum, t_dif, t_neg;
  logic signed [63:0]  m_p1, m_p2;
  scm_pkg::q30_t       p1, z_d, p2;
  logic signed [WB-1:0] wet6;

  // ---- early modes ----
  logic signed [30:0]  a30_e, b30_e, a30_q, b30_q;
  logic [30:0]         mb_e;
  logic signed [63:0]  m_ph0, m_ab, m_sq, m_tr;
  logic [31:0]         ph0;
  scm_pkg::q30_t       s0, sa, sb, p_ab;
  scm_pkg::q30_t       sq_sum, sq_dif, sq, nd_r, w4_d;
  logic signed [33:0]  w5;
  scm_pkg::wide_t      w_e;
  logic signed [WB-1:0] wet_e, wet_sel, dir_w;
  logic [SAMPLE_BITS-1:0] abs_a, abs_b;

  // ---- mix and output ----
  logic signed [SAMPLE_BITS+16:0] mdry;
  logic signed [WB+16:0]          mwet;
  logic signed [AW-1:0]           sum_c, rnd_c, sat_c;

  // Take writes whenever the port is up; writes beyond the list are dropped.
  assign cfg_ready = ~busy;
  assign mix_eff   = (mix > scm_pkg::MIX_FULL) ? scm_pkg::MIX_FULL : mix;
  assign inv_mix   = scm_pkg::MIX_FULL - mix_eff;
  assign done      = vld[scm_pkg::STG_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      vld  <= '0;
      mode <= scm_pkg::MODE_SINPROD;
      mix  <= scm_pkg::MIX_RESET;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[scm_pkg::STG_OUT-1:1], start & ~busy};
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          scm_pkg::REG_MODE: mode <= cfg_data[2:0];
          scm_pkg::REG_MIX:  mix  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Advance both samples every cycle; valid bits say which slots matter.
  always_ff @(posedge clk) begin
    ad[1] <= main_sample;
    bd[1] <= side_sample;
    for (int k = 2; k <= AD_LEN; k++) begin
      ad[k] <= ad[k-1];
    end
    for (int k = 2; k <= BD_LEN; k++) begin
      bd[k] <= bd[k-1];
    end
  end

  // ---- mode 6: -sin(tan(a+b)) * sin(tan(a-b)) * sin(tan(b-a)) ----
  assign a30_1 = to_q30(ad[1]);
  assign b30_1 = to_q30(bd[1]);
  assign v_sum = 32'(a30_1) + 32'(b30_1);
  assign v_dif = 32'(a30_1) - 32'(b30_1);
  assign v_neg = 32'(b30_1) - 32'(a30_1);

  scm_sot u_sot_sum (.clk(clk), .v(v_sum), .sot(t_sum));
  scm_sot u_sot_dif (.clk(clk), .v(v_dif), .sot(t_dif));
  scm_sot u_sot_neg (.clk(clk), .v(v_neg), .sot(t_neg));

  assign m_p1 = t_sum * t_dif;
  assign m_p2 = p1 * z_d;

  always_ff @(posedge clk) begin
    p1   <= m_p1[61:30];
    z_d  <= t_neg;
    p2   <= m_p2[61:30];
    wet6 <= wet_fix(-35'(p2));
  end

  // ---- modes 0 to 5: timed so their wet value lands beside mode 6 ----
  assign a30_e = to_q30(ad[STG_E]);
  assign b30_e = to_q30(bd[STG_E]);
  assign mb_e  = b30_e[30] ? 31'(-b30_e) : b30_e;
  assign m_ph0 = a30_e * $signed({1'b0, mb_e});

  scm_sin u_sin_0 (.clk(clk), .phase(ph0), .sin_val(s0));
  scm_sin u_sin_a (.clk(clk), .phase({a30_e, 1'b0}), .sin_val(sa));
  scm_sin u_sin_b (.clk(clk), .phase({b30_e, 1'b0}), .sin_val(sb));

  assign m_ab   = sa * sb;
  assign a30_q  = to_q30(ad[STG_Q]);
  assign b30_q  = to_q30(bd[STG_Q]);
  assign sq_sum = 32'(a30_q) + 32'(b30_q);
  assign sq_dif = 32'(a30_q) - 32'(b30_q);
  assign m_sq   = sq_sum * sq_dif;
  assign m_tr   = sq * nd_r;

  // Magnitude compare; -min wraps to the right unsigned magnitude.
  assign abs_a = ad[scm_pkg::STG_WET-1][SAMPLE_BITS-1] ? SAMPLE_BITS'(-ad[scm_pkg::STG_WET-1])
                                                       : ad[scm_pkg::STG_WET-1];
  assign abs_b = bd[scm_pkg::STG_WET-1][SAMPLE_BITS-1] ? SAMPLE_BITS'(-bd[scm_pkg::STG_WET-1])
                                                       : bd[scm_pkg::STG_WET-1];

  always_comb begin
    if (mode == scm_pkg::MODE_MINMAG) begin
      dir_w = (abs_b < abs_a) ? WB'(bd[scm_pkg::STG_WET-1]) : WB'(ad[scm_pkg::STG_WET-1]);
    end else begin
      dir_w = (abs_b > abs_a) ? WB'(bd[scm_pkg::STG_WET-1]) : WB'(ad[scm_pkg::STG_WET-1]);
    end
  end

  always_ff @(posedge clk) begin
    ph0  <= m_ph0[61:30];
    p_ab <= m_ab[61:30];
    sq   <= m_sq[61:30];
    nd_r <= 32'(b30_q) - 32'(a30_q);
    w4_d <= sq;
    w5   <= m_tr[63:30];
    case (mode)
      scm_pkg::MODE_SINPROD: w_e <= 35'(s0);
      scm_pkg::MODE_SINSIN:  w_e <= 35'(p_ab);
      scm_pkg::MODE_DIFFSQ:  w_e <= 35'(w4_d);
      scm_pkg::MODE_TRIPLE:  w_e <= 35'(w5);
      default:               w_e <= '0;
    endcase
    if (mode == scm_pkg::MODE_MINMAG || mode == scm_pkg::MODE_MAXMAG) begin
      wet_e <= dir_w;
    end else begin
      wet_e <= wet_fix(w_e);
    end
  end

  // ---- dry/wet blend, round half up by 15 bits, saturate ----
  assign wet_sel = (mode == scm_pkg::MODE_SINTAN) ? wet6 : wet_e;
  assign sum_c   = AW'(mdry) + AW'(mwet) + MHALF;
  assign rnd_c   = sum_c >>> 15;
  assign sat_c   = (rnd_c > SMAX) ? SMAX : ((rnd_c < SMIN) ? SMIN : rnd_c);

  always_ff @(posedge clk) begin
    mdry <= ad[scm_pkg::STG_MIX-1] * $signed({1'b0, inv_mix});
    mwet <= wet_sel * $signed({1'b0, mix_eff});
    // pass-through mode ignores mix and hands main on untouched
    out_sample <= (mode == scm_pkg::MODE_THRU) ? ad[scm_pkg::STG_MIX] : sat_c[SAMPLE_BITS-1:0];
  end

  // ---- checks ----
  `SCM_CHECK(a_done_not_busy, done, !busy, "result strobe while busy")
  `SCM_CHECK(a_dry_only, done && mode != scm_pkg::MODE_THRU && mix_eff == '0, out_sample == $past(ad[scm_pkg::STG_MIX]), "zero mix must return the dry sample")
  `SCM_CHECK_NEXT(a_pick_sample, vld[scm_pkg::STG_WET-1] && (mode == scm_pkg::MODE_MINMAG || mode == scm_pkg::MODE_MAXMAG), wet_e == WB'($past(ad[scm_pkg::STG_WET-1])) || wet_e == WB'($past(bd[scm_pkg::STG_WET-1])), "magnitude pick is neither sample")

endmodule

`default_nettype wire

### bench/tb_sidechain_combine_mixer_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Sidechain combine mixer unit bench
// Drives sample pairs through every mode and a range of mix settings, with
// bursty start traffic, and checks each done word against a bit-exact
// fixed-point blend predictor kept in a small scoreboard class.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_sidechain_combine_mixer_unit;

  localparam int SB        = 16;
  localparam int LATENCY   = 56;
  localparam int CYCLE_CAP = 400000;
  localparam longint K_TURN = 64'sd683565276;
  localparam longint Q30_ONE = 64'sd1073741824;

  // Blend predictor plus store of pending output samples
  class blend_board;
    logic [2:0]  mode_q;
    logic [15:0] mix_q;
    logic signed [SB-1:0] pending[$];
    int errors;

    function new();
      mode_q = scm_pkg::MODE_SINPROD;
      mix_q  = scm_pkg::MIX_RESET;
      errors = 0;
    endfunction

    function void reg_write(logic [scm_pkg::CFG_IDX_BITS-1:0] idx, logic [15:0] data);
      if (idx == scm_pkg::REG_MODE) mode_q = data[2:0];
      else if (idx == scm_pkg::REG_MIX) mix_q = data;
    endfunction

    // sine of a turn phase, Q.30
    function longint sine(bit [31:0] ph);
      longint f, x, y, acc, r;
      f = longint'(ph[29:0]);
      x = ph[30] ? Q30_ONE - f : f;
      y = (x * x) >>> 30;
      acc = 64'sd172272;
      acc = 64'sd5026995 - ((acc * y) >>> 30);
      acc = 64'sd85569306 - ((acc * y) >>> 30);
      acc = 64'sd693598669 - ((acc * y) >>> 30);
      acc = 64'sd1686629713 - ((acc * y) >>> 30);
      r = (acc * x) >>> 30;
      if (r > Q30_ONE) r = Q30_ONE;
      return ph[31] ? -r : r;
    endfunction

    function longint sin_tan(longint v30);
      bit [63:0] p;
      bit [31:0] ph;
      longint s, c, t;
      p = v30 * K_TURN;
      ph = p[61:30];
      s = sine(ph);
      c = sine(ph + 32'h4000_0000);
      if (c == 0) t = (s < 0) ? -(64'sd32768 <<< 16) : (64'sd32768 <<< 16);
      else begin
        t = (s * 64'sd65536) / c;
        if (t > (64'sd32768 <<< 16)) t = 64'sd32768 <<< 16;
        if (t < -(64'sd32768 <<< 16)) t = -(64'sd32768 <<< 16);
      end
      p = t * K_TURN;
      return sine(p[47:16]);
    endfunction

    function logic signed [SB-1:0] blend(logic signed [SB-1:0] m, logic signed [SB-1:0] s);
      longint a, b, a30, b30, w30, wet, mx, acc, ma, mb;
      bit [63:0] p;
      bit direct;
      a = m; b = s;
      a30 = a <<< 15; b30 = b <<< 15;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      mx = (mix_q > scm_pkg::MIX_FULL) ? 64'sd32768 : longint'(mix_q);
      direct = 0; w30 = 0; wet = 0;
      case (mode_q)
        scm_pkg::MODE_SINPROD: begin
          p = a30 * (b30 < 0 ? -b30 : b30);
          w30 = sine(p[61:30]);
        end
        scm_pkg::MODE_SINSIN: begin
          p = a30 * 2;
          w30 = sine(p[31:0]);
          p = b30 * 2;
          w30 = (w30 * sine(p[31:0])) >>> 30;
        end
        scm_pkg::MODE_MINMAG: begin wet = (mb < ma) ? b : a; direct = 1; end
        scm_pkg::MODE_MAXMAG: begin wet = (mb > ma) ? b : a; direct = 1; end
        scm_pkg::MODE_DIFFSQ: w30 = ((a30 + b30) * (a30 - b30)) >>> 30;
        scm_pkg::MODE_TRIPLE:
          w30 = ((((a30 + b30) * (a30 - b30)) >>> 30) * (b30 - a30)) >>> 30;
        scm_pkg::MODE_SINTAN:
          w30 = -((((sin_tan(a30 + b30) * sin_tan(a30 - b30)) >>> 30)
                   * sin_tan(b30 - a30)) >>> 30);
        default: return m;
      endcase
      if (!direct) begin
        wet = (w30 + 64'sd16384) >>> 15;
        if (wet > 64'sd131071) wet = 64'sd131071;
        if (wet < -64'sd131072) wet = -64'sd131072;
      end
      acc = (a * (64'sd32768 - mx) + wet * mx + 64'sd16384) >>> 15;
      if (acc > 64'sd32767) acc = 64'sd32767;
      if (acc < -64'sd32768) acc = -64'sd32768;
      return acc[SB-1:0];
    endfunction

    function void note(logic signed [SB-1:0] m, logic signed [SB-1:0] s);
      pending.push_back(blend(m, s));
    endfunction

    function void check(logic signed [SB-1:0] got);
      logic signed [SB-1:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected out_sample %0d", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: out_sample mismatch, expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, done, cfg_ready;
  logic signed [SB-1:0] main_sample = '0;
  logic signed [SB-1:0] side_sample = '0;
  logic signed [SB-1:0] out_sample;
  logic cfg_valid = 0;
  logic [scm_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [scm_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  blend_board board = new();
  int burst_left = 0;
  int cycles = 0;

  always #5 clk = ~clk;

  sidechain_combine_mixer_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .main_sample(main_sample), .side_sample(side_sample),
    .done(done), .out_sample(out_sample),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // check every done word at the edge that ends its cycle
  always @(posedge clk) begin
    if (!rst && done) board.check(out_sample);
  end

  // hard stop on a hang
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Send one word; start stays high across a burst, drops only for a gap
  task automatic send_pair(logic signed [SB-1:0] m, logic signed [SB-1:0] s);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start = 0;
        repeat (gap - 1) @(negedge clk);
        @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    main_sample = m;
    side_sample = s;
    start = 1;
    do @(posedge clk); while (busy);
    board.note(m, s);
    burst_left--;
  endtask

  // Hold until every pending word has come back, then let the pipe flush
  task automatic drain();
    @(negedge clk);
    start = 0;
    burst_left = 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic [scm_pkg::CFG_IDX_BITS-1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    board.reg_write(idx, data);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic logic signed [SB-1:0] pick_sample();
    logic signed [SB-1:0] edges[5] = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    case ($urandom_range(0, 7))
      0: return edges[$urandom_range(0, 4)];
      1: return SB'($urandom_range(0, 512) - 256);
      default: return SB'($urandom());
    endcase
  endfunction

  initial begin
    logic [15:0] mixes[12] = '{16'd32768, 16'd0, 16'd16384, 16'd1, 16'd65535, 16'd40000,
                               16'd32767, 16'd8192, 16'd24576, 16'd32768, 16'd0, 16'd32769};
    logic signed [SB-1:0] m, s;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // reset settings first (mode 0, mix half), then a dead register index
    send_pair(16'sd32767, -16'sd32768);
    send_pair(-16'sd12000, 16'sd12000);
    drain();
    write_reg(4'd5, 16'hFFFF);

    for (int ph = 0; ph < 12; ph++) begin
      drain();
      write_reg(scm_pkg::REG_MODE, 16'((ph == 11) ? (16'hFFF8 | ph % 8) : ph % 8));
      write_reg(scm_pkg::REG_MIX, mixes[ph]);
      if (ph < 8) begin
        // extremes, magnitude ties and zero for this mode
        send_pair(16'sd32767, 16'sd32767);
        send_pair(-16'sd32768, -16'sd32768);
        send_pair(-16'sd32768, 16'sd32767);
        send_pair(16'sd0, 16'sd0);
        send_pair(16'sd1234, -16'sd1234);
        send_pair(-16'sd1, 16'sd1);
      end
      if (ph == 6) drain();
      for (int i = 0; i < 115; i++) begin
        m = pick_sample();
        s = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? m : -m) : pick_sample();
        send_pair(m, s);
      end
    end

    @(negedge clk);
    start = 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+design
design/scm_pkg.sv
design/scm_sin.sv
design/scm_sot.sv
design/sidechain_combine_mixer_unit.sv
bench/tb_sidechain_combine_mixer_unit.sv
